// ===== rtl/core/smme_pkg.sv =====
// shared types and constants of the sliding min/max envelope core
// no dependencies; imported by smme_deque, smme_ctrl, the top level and the testbench
`default_nettype none

package smme_pkg;

   // sequence position counter, wraps; ages are taken modulo its range
   localparam int POS_WIDTH = 7;

   // radius register
   localparam int RADIUS_WIDTH = 5;
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 5'd4;

   // defaults of the top level parameters
   localparam int DEF_MAX_RADIUS = 31;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // register port: 32-bit words, register i at byte address 4*i
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RADIUS = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_TRIM
   } smme_state_type;

   // command to one deque for the current cycle
   typedef struct packed {
      logic clear;
      logic push;
      logic trim;
   } smme_dq_cmd_type;

   // status of one deque in the current cycle
   typedef struct packed {
      logic wrote;
      logic front_ok;
      logic empty;
   } smme_dq_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/smme_ram.sv =====
// generic synchronous ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module smme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_a_addr,
   output logic      [WIDTH-1:0] rd_a_data,
   input  wire logic [AW-1:0]    rd_b_addr,
   output logic      [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/smme_deque.sv =====
// monotonic max deque of (value, position) held in a ring in smme_ram
// depends on smme_pkg and smme_ram; a min deque is fed inverted samples
`default_nettype none

module smme_deque #(
   parameter int SAMPLE_WIDTH = smme_pkg::DEF_SAMPLE_WIDTH,
   parameter int MAX_RADIUS = smme_pkg::DEF_MAX_RADIUS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire smme_pkg::smme_dq_cmd_type          cmd,
   input  wire logic signed [SAMPLE_WIDTH-1:0]     value,
   input  wire logic [smme_pkg::POS_WIDTH-1:0]     now,
   input  wire logic [smme_pkg::POS_WIDTH-1:0]     limit,
   output smme_pkg::smme_dq_stat_type              stat,
   output logic signed [SAMPLE_WIDTH-1:0]          front
);
   import smme_pkg::*;

   localparam int DEPTH = 2 * MAX_RADIUS + 2;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = SAMPLE_WIDTH + POS_WIDTH;

   function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
      return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
      return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
   endfunction

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic tpend_ff, tpend_in;
   logic hpend_ff, hpend_in;
   logic signed [SAMPLE_WIDTH-1:0] tail_val_ff, tail_val_in;
   logic signed [SAMPLE_WIDTH-1:0] head_val_ff, head_val_in;
   logic [POS_WIDTH-1:0] head_pos_ff, head_pos_in;

   logic [EW-1:0] rd_a_data, rd_b_data;
   logic [AW-1:0] wr_addr;
   logic wr_en;

   logic signed [SAMPLE_WIDTH-1:0] tail_cur, head_cur_val;
   logic [POS_WIDTH-1:0] head_cur_pos, age;
   logic is_empty, tail_pop, do_write, stale, head_pop;

   // caches hold the end entries; after a pop the new end comes from the ram
   assign tail_cur = tpend_ff ? $signed(rd_a_data[SAMPLE_WIDTH-1:0]) : tail_val_ff;
   assign head_cur_val = hpend_ff ? $signed(rd_b_data[SAMPLE_WIDTH-1:0]) : head_val_ff;
   assign head_cur_pos = hpend_ff ? rd_b_data[EW-1:SAMPLE_WIDTH] : head_pos_ff;

   assign is_empty = (count_ff == '0);
   assign tail_pop = cmd.push && !is_empty && (tail_cur <= value);
   assign do_write = cmd.push && !tail_pop;
   assign age = now - head_cur_pos;
   assign stale = !is_empty && (age > limit);
   assign head_pop = cmd.trim && stale;
   assign wr_addr = is_empty ? head_ff : idx_inc(tail_ff);
   assign wr_en = do_write && !cmd.clear;

   smme_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   ({now, value}),
      .rd_a_addr (idx_dec(tail_ff)),
      .rd_a_data (rd_a_data),
      .rd_b_addr (idx_inc(head_ff)),
      .rd_b_data (rd_b_data)
   );

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      tail_val_in = tail_cur;
      head_val_in = head_cur_val;
      head_pos_in = head_cur_pos;
      tpend_in = tail_pop;
      hpend_in = head_pop;
      if (cmd.clear) begin
         head_in = '0;
         tail_in = '0;
         count_in = '0;
         tpend_in = 1'b0;
         hpend_in = 1'b0;
      end else if (tail_pop) begin
         count_in = count_ff - 1'b1;
         tail_in = idx_dec(tail_ff);
      end else if (do_write) begin
         count_in = count_ff + 1'b1;
         tail_in = wr_addr;
         tail_val_in = value;
         if (is_empty) begin
            head_val_in = value;
            head_pos_in = now;
         end
      end else if (head_pop) begin
         count_in = count_ff - 1'b1;
         head_in = idx_inc(head_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         tpend_ff <= 1'b0;
         hpend_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         tpend_ff <= tpend_in;
         hpend_ff <= hpend_in;
      end
      tail_val_ff <= tail_val_in;
      head_val_ff <= head_val_in;
      head_pos_ff <= head_pos_in;
   end

   assign stat.wrote = do_write;
   assign stat.front_ok = !stale;
   assign stat.empty = is_empty;
   assign front = is_empty ? '0 : head_cur_val;

endmodule

`default_nettype wire

// ===== rtl/core/smme_ctrl.sv =====
// sequencer of the envelope core: item intake, deque commands, result register
// depends on smme_pkg
`default_nettype none

module smme_ctrl #(
   parameter int SAMPLE_WIDTH = smme_pkg::DEF_SAMPLE_WIDTH,
   parameter int MAX_RADIUS = smme_pkg::DEF_MAX_RADIUS,
   localparam int RW = $clog2(MAX_RADIUS + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [RW-1:0]                   radius,
   input  wire logic                            cfg_clear,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]  req_sample,
   input  wire logic                            req_seq_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_lower,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_upper,
   output logic                                 rsp_result_last,
   output smme_pkg::smme_dq_cmd_type            min_cmd,
   output smme_pkg::smme_dq_cmd_type            max_cmd,
   output logic signed [SAMPLE_WIDTH-1:0]       min_value,
   output logic signed [SAMPLE_WIDTH-1:0]       max_value,
   output logic [smme_pkg::POS_WIDTH-1:0]       now,
   output logic [smme_pkg::POS_WIDTH-1:0]       limit,
   input  wire smme_pkg::smme_dq_stat_type      min_stat,
   input  wire logic signed [SAMPLE_WIDTH-1:0]  min_front,
   input  wire smme_pkg::smme_dq_stat_type      max_stat,
   input  wire logic signed [SAMPLE_WIDTH-1:0]  max_front
);
   import smme_pkg::*;

   smme_state_type state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic last_ff, last_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [RW-1:0] seen_ff, seen_in;
   logic [RW-1:0] lag_ff, lag_in;
   logic [1:0] done_ff, done_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_lower_ff, rsp_lower_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_upper_ff, rsp_upper_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept, push_active, push_all, warm, out_free, emit, flush_more, seq_end;
   logic cur_last;
   logic signed [SAMPLE_WIDTH-1:0] cur_sample;
   smme_state_type post_push_state;

   assign accept = (state_ff == ST_IDLE) && req_valid;
   assign push_active = accept || (state_ff == ST_PUSH);
   assign cur_sample = (state_ff == ST_IDLE) ? req_sample : sample_ff;
   assign cur_last = (state_ff == ST_IDLE) ? req_seq_last : last_ff;
   assign push_all = push_active && (done_ff[0] || min_stat.wrote)
                                 && (done_ff[1] || max_stat.wrote);
   assign warm = (seen_ff >= radius);
   assign post_push_state = (warm || cur_last) ? ST_TRIM : ST_IDLE;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit = (state_ff == ST_TRIM) && min_stat.front_ok && max_stat.front_ok
                 && out_free;
   assign flush_more = last_ff && (lag_ff != '0);
   assign seq_end = emit && !flush_more && last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = push_all ? post_push_state : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_all) begin
               state_in = post_push_state;
            end
         end
         ST_TRIM: begin
            if (emit && !flush_more) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cfg_clear) begin
         state_in = ST_IDLE;
      end
   end

   // outputs and datapath
   always_comb begin
      min_cmd.clear = cfg_clear || seq_end;
      max_cmd.clear = cfg_clear || seq_end;
      min_cmd.push = push_active && !done_ff[0];
      max_cmd.push = push_active && !done_ff[1];
      min_cmd.trim = (state_ff == ST_TRIM);
      max_cmd.trim = (state_ff == ST_TRIM);
      max_value = cur_sample;
      min_value = ~cur_sample;
      now = pos_ff;
      limit = POS_WIDTH'(lag_ff) + POS_WIDTH'(radius);
      req_stall = (state_ff != ST_IDLE);

      sample_in = accept ? req_sample : sample_ff;
      last_in = accept ? req_seq_last : last_ff;
      pos_in = pos_ff;
      seen_in = seen_ff;
      lag_in = lag_ff;
      done_in = done_ff;

      if (push_all) begin
         done_in = '0;
         if (warm) begin
            lag_in = radius;
         end else begin
            seen_in = seen_ff + 1'b1;
            if (cur_last) begin
               lag_in = seen_ff;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end else if (push_active) begin
         done_in = done_ff | {max_stat.wrote, min_stat.wrote};
      end

      if (emit) begin
         if (flush_more) begin
            lag_in = lag_ff - 1'b1;
         end else if (last_ff) begin
            pos_in = '0;
            seen_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      if (cfg_clear) begin
         pos_in = '0;
         seen_in = '0;
         done_in = '0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_lower_in = rsp_lower_ff;
      rsp_upper_in = rsp_upper_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_lower_in = min_stat.empty ? '0 : ~min_front;
         rsp_upper_in = max_front;
         rsp_last_in = last_ff && (lag_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         seen_ff <= '0;
         lag_ff <= '0;
         done_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         seen_ff <= seen_in;
         lag_ff <= lag_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      last_ff <= last_in;
      rsp_lower_ff <= rsp_lower_in;
      rsp_upper_ff <= rsp_upper_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lower = rsp_lower_ff;
   assign rsp_upper = rsp_upper_ff;
   assign rsp_result_last = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_min_max_envelope_core.sv =====
// Sliding min/max envelope core. For every sample of a sequence it returns the
// minimum (lower) and maximum (upper) over the samples within radius of it,
// clipped to the sequence. A result leaves radius samples after its center;
// the sample marked seq_last releases its own result and all remaining ones,
// the final one flagged by rsp_result_last, and the next sample starts a new
// sequence. Each of the two monotonic deques lives in a ring ram of
// 2*MAX_RADIUS+2 entries (64 by default; one write, two registered read
// ports) with cached head and tail entries. Once radius samples precede it,
// a sample is first pushed into both deques, then trims stale head entries
// and emits; a sample still inside the warm-up is only pushed. Every
// dominated tail entry dropped on a push delays the push (the next tail
// comes from a ram read); every head entry aged out of the window delays
// the emit likewise. Each entry is dropped at most once. The last sample of
// a sequence also emits each remaining flushed result in turn. The result
// register lets a new sample in while a result waits on rsp_stall. Writing
// the radius register (address 0) clears the sequence state; a partial
// sequence is dropped. Radius above MAX_RADIUS is clamped to it.
// depends on smme_pkg, smme_ctrl, smme_deque, smme_ram
`default_nettype none

module sliding_min_max_envelope_core #(
   parameter int SAMPLE_WIDTH = smme_pkg::DEF_SAMPLE_WIDTH,
   parameter int MAX_RADIUS = smme_pkg::DEF_MAX_RADIUS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // sample items
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   input  wire logic                                   req_seq_last,
   // envelope items
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_lower,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_upper,
   output logic                                        rsp_result_last,
   // register port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [smme_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [smme_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic      [smme_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                        csr_pready
);
   import smme_pkg::*;

   localparam int RW = $clog2(MAX_RADIUS + 1);

   // radius register
   logic [RADIUS_WIDTH-1:0] radius_ff, radius_in;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic csr_wr_radius;
   logic [RW-1:0] radius_eff;

   // deque command and status
   smme_dq_cmd_type min_cmd, max_cmd;
   smme_dq_stat_type min_stat, max_stat;
   logic signed [SAMPLE_WIDTH-1:0] min_value, max_value, min_front, max_front;
   logic [POS_WIDTH-1:0] now, limit;

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[CSR_ADDR_WIDTH-1:2];
   // write completes on the access cycle
   assign csr_wr_radius = csr_psel && csr_penable && csr_pwrite && csr_pready
                          && (csr_index == REG_RADIUS);
   assign radius_in = csr_wr_radius ? csr_pwdata[RADIUS_WIDTH-1:0] : radius_ff;
   assign csr_prdata = (csr_index == REG_RADIUS) ? CSR_DATA_WIDTH'(radius_ff) : '0;

   // clamp the programmed radius to what the deques are sized for
   assign radius_eff = (int'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   smme_ctrl #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_RADIUS   (MAX_RADIUS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .radius          (radius_eff),
      .cfg_clear       (csr_wr_radius),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_seq_last    (req_seq_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lower       (rsp_lower),
      .rsp_upper       (rsp_upper),
      .rsp_result_last (rsp_result_last),
      .min_cmd         (min_cmd),
      .max_cmd         (max_cmd),
      .min_value       (min_value),
      .max_value       (max_value),
      .now             (now),
      .limit           (limit),
      .min_stat        (min_stat),
      .min_front       (min_front),
      .max_stat        (max_stat),
      .max_front       (max_front)
   );

   // min deque runs on inverted samples, so the same falling deque serves both
   smme_deque #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_RADIUS   (MAX_RADIUS)
   ) u_min_dq (
      .clock (clock),
      .reset (reset),
      .cmd   (min_cmd),
      .value (min_value),
      .now   (now),
      .limit (limit),
      .stat  (min_stat),
      .front (min_front)
   );

   smme_deque #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_RADIUS   (MAX_RADIUS)
   ) u_max_dq (
      .clock (clock),
      .reset (reset),
      .cmd   (max_cmd),
      .value (max_value),
      .now   (now),
      .limit (limit),
      .stat  (max_stat),
      .front (max_front)
   );

   // an accepted sample is pushed into both deques in the same cycle
   a_accept_pushes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> min_cmd.push && max_cmd.push)
      else $error("accepted item not pushed into both deques");

   // the newest sample never ages out, so an emitting trim sees both deques filled
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      min_cmd.trim && min_stat.front_ok && max_stat.front_ok
      |-> !min_stat.empty && !max_stat.empty)
      else $error("envelope taken from an empty deque");

   // a write leaves the deque non-empty
   a_min_write_fills: assert property (@(posedge clock) disable iff (reset)
      min_stat.wrote && !min_cmd.clear |=> !min_stat.empty)
      else $error("min deque empty after a push");

   a_max_write_fills: assert property (@(posedge clock) disable iff (reset)
      max_stat.wrote && !max_cmd.clear |=> !max_stat.empty)
      else $error("max deque empty after a push");

endmodule

`default_nettype wire

// ===== verif/sliding_min_max_envelope_core_tb.sv =====
// self-checking testbench of the sliding min/max envelope core
// depends on smme_pkg and sliding_min_max_envelope_core; reads no files
`timescale 1ns / 1ps

module sliding_min_max_envelope_core_tb;
   import smme_pkg::*;

   localparam int SAMPLE_BITS = DEF_SAMPLE_WIDTH;
   localparam int RADIUS_CAP = DEF_MAX_RADIUS;
   localparam int SETTLE_CYCLES = 64;     // covers trim work of an item with no result
   localparam int HOLD_CYCLES = 400;      // long receiver hold-off
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [CSR_INDEX_WIDTH-1:0] SPARE_INDEX = REG_RADIUS + 1'b1;
   localparam logic [CSR_ADDR_WIDTH-1:0] RADIUS_ADDR = {REG_RADIUS, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR = {SPARE_INDEX, 2'b00};
   localparam logic signed [SAMPLE_BITS-1:0] MIN_SAMPLE =
      SAMPLE_BITS'(-(2 ** (SAMPLE_BITS - 1)));
   localparam logic signed [SAMPLE_BITS-1:0] MAX_SAMPLE =
      SAMPLE_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);

   // shapes of random sample content
   typedef enum int {
      PAT_UNIFORM,
      PAT_NARROW,
      PAT_RAMP,
      PAT_EXTREME
   } sample_pattern_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] lower;
      logic signed [SAMPLE_BITS-1:0] upper;
      logic                          last;
   } envelope_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // sample channel
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_seq_last = 1'b0;

   // envelope channel
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_lower;
   logic signed [SAMPLE_BITS-1:0] rsp_upper;
   logic                          rsp_result_last;

   // register port
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // predictor state: radius in force and samples of the open sequence
   int                            active_radius = int'(RADIUS_RESET);
   logic signed [SAMPLE_BITS-1:0] seq_samples[$];
   envelope_type                  env_expected[$];

   // idle rates in percent, hold-off bookkeeping, run statistics
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int error_count = 0;
   int checked_count = 0;
   int samples_sent = 0;
   int radius_writes = 0;

   sliding_min_max_envelope_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_seq_last    (req_seq_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lower       (rsp_lower),
      .rsp_upper       (rsp_upper),
      .rsp_result_last (rsp_result_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit, well above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d envelope items still owed",
                  cycle_count, env_expected.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // compare every accepted envelope item with the oldest one owed
   always @(posedge clock) begin
      envelope_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (env_expected.size() == 0) begin
            $error("unexpected envelope item: lower %0d upper %0d last %0b",
                   rsp_lower, rsp_upper, rsp_result_last);
            error_count++;
         end else begin
            owed = env_expected.pop_front();
            checked_count++;
            if (rsp_lower !== owed.lower) begin
               $error("lower mismatch: expected %0d, got %0d", owed.lower, rsp_lower);
               error_count++;
            end
            if (rsp_upper !== owed.upper) begin
               $error("upper mismatch: expected %0d, got %0d", owed.upper, rsp_upper);
               error_count++;
            end
            if (rsp_result_last !== owed.last) begin
               $error("result_last mismatch: expected %0b, got %0b",
                      owed.last, rsp_result_last);
               error_count++;
            end
         end
      end
   end

   // min and max over the window around center, clipped to the samples seen so far
   function automatic envelope_type window_envelope(input int center, input bit last_flag);
      envelope_type env;
      int lo_pos;
      int hi_pos;
      lo_pos = (center - active_radius < 0) ? 0 : center - active_radius;
      hi_pos = center + active_radius;
      if (hi_pos > seq_samples.size() - 1)
         hi_pos = seq_samples.size() - 1;
      env.lower = seq_samples[lo_pos];
      env.upper = seq_samples[lo_pos];
      for (int p = lo_pos + 1; p <= hi_pos; p++) begin
         if (seq_samples[p] < env.lower)
            env.lower = seq_samples[p];
         if (seq_samples[p] > env.upper)
            env.upper = seq_samples[p];
      end
      env.last = last_flag;
      return env;
   endfunction

   // results lag by radius; the closing sample releases every center still open
   task automatic predict_envelope(input logic signed [SAMPLE_BITS-1:0] value,
                                   input bit seq_end);
      int n;
      int first_open;
      seq_samples.push_back(value);
      n = seq_samples.size();
      if (n - 1 >= active_radius)
         env_expected.push_back(window_envelope(n - 1 - active_radius,
                                                seq_end && active_radius == 0));
      if (seq_end) begin
         first_open = (n > active_radius) ? n - active_radius : 0;
         for (int c = first_open; c < n; c++)
            env_expected.push_back(window_envelope(c, c == n - 1));
         seq_samples.delete();
      end
   endtask

   // offer one sample, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                              input bit seq_end);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      req_seq_last <= seq_end;
      do
         @(posedge clock);
      while (req_stall);
      predict_envelope(value, seq_end);
      samples_sent++;
   endtask

   // one sequence of random content, closed by seq_last when asked
   task automatic send_sequence(input int len, input bit seq_end);
      sample_pattern_type pattern;
      logic signed [SAMPLE_BITS-1:0] value;
      bit rising;
      pattern = sample_pattern_type'($urandom_range(0, 3));
      value = SAMPLE_BITS'($urandom);
      rising = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         case (pattern)
            PAT_UNIFORM: value = SAMPLE_BITS'($urandom);
            // narrow range gives many equal values
            PAT_NARROW: value = SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
            // long monotonic runs empty one deque and fill the other
            PAT_RAMP: begin
               if ($urandom_range(0, 7) == 0)
                  rising = !rising;
               value = rising ? SAMPLE_BITS'(value + int'($urandom_range(0, 300)))
                              : SAMPLE_BITS'(value - int'($urandom_range(0, 300)));
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: value = MIN_SAMPLE;
                  1: value = MAX_SAMPLE;
                  2: value = '0;
                  default: value = '1;
               endcase
            end
         endcase
         send_sample(value, seq_end && i == len - 1);
      end
   endtask

   // drop valid, wait out every owed item, then let trailing work finish
   task automatic settle();
      req_valid <= 1'b0;
      while (env_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup cycle, access cycle, then the port is released
   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_WIDTH-1:0] addr,
                             input logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_radius(input int expected);
      logic [CSR_DATA_WIDTH-1:0] rd;
      csr_access(1'b0, RADIUS_ADDR, '0, rd);
      if (rd[RADIUS_WIDTH-1:0] !== expected[RADIUS_WIDTH-1:0]) begin
         $error("radius mismatch: expected %0d, got %0d", expected, rd[RADIUS_WIDTH-1:0]);
         error_count++;
      end
   endtask

   // a radius write also drops any open sequence; random upper bits are ignored
   task automatic write_radius(input int value);
      logic [CSR_DATA_WIDTH-1:0] rd;
      settle();
      csr_access(1'b1, RADIUS_ADDR, ($urandom & ~32'h1f) | value, rd);
      active_radius = (value > RADIUS_CAP) ? RADIUS_CAP : value;
      seq_samples.delete();
      radius_writes++;
      check_radius(value);
   endtask

   function automatic int pick_radius();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return RADIUS_CAP;
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   // corner samples, short and single-sample sequences, radius zero,
   // a write to an unused address, and a sequence cut short by a radius write
   task automatic test_directed();
      logic signed [SAMPLE_BITS-1:0] corner[9];
      logic [CSR_DATA_WIDTH-1:0] rd;
      corner = '{MIN_SAMPLE, MAX_SAMPLE, '0, '1, SAMPLE_BITS'(1), MAX_SAMPLE, MIN_SAMPLE,
                 16'sh5555, 16'shaaaa};
      check_radius(int'(RADIUS_RESET));
      foreach (corner[i])
         send_sample(corner[i], i == 8);
      // shorter than the reset radius
      send_sequence(3, 1'b1);
      send_sample(MAX_SAMPLE, 1'b1);
      write_radius(0);
      send_sequence(3, 1'b1);
      // unused address must neither change the radius nor break the open sequence
      write_radius(2);
      send_sequence(3, 1'b0);
      settle();
      csr_access(1'b1, SPARE_ADDR, $urandom, rd);
      check_radius(2);
      send_sequence(2, 1'b1);
      // open sequence dropped by the radius write
      send_sequence(3, 1'b0);
      write_radius(2);
      send_sequence(2, 1'b1);
   endtask

   // random sequences, radius changed between some of them
   task automatic test_random_sequences(input int send_pct, input int recv_pct,
                                        input int budget);
      int sent;
      int len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      write_radius(pick_radius());
      while (sent < budget) begin
         if ($urandom_range(0, 2) == 0)
            write_radius(pick_radius());
         if ($urandom_range(0, 7) == 0)
            len = 1;
         else if (active_radius > 12)
            len = $urandom_range(1, 40);
         else
            len = $urandom_range(1, 2 * active_radius + 6);
         send_sequence(len, 1'b1);
         sent += len;
      end
   endtask

   // long sequence at the widest radius, past the wrap of the position counter
   task automatic test_position_wrap();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_radius(RADIUS_CAP);
      send_sequence(135, 1'b1);
   endtask

   // receiver holds off while samples keep coming, so the input stalls
   task automatic test_output_backpressure();
      write_radius(6);
      hold_requests++;
      repeat (3) send_sequence(10, 1'b1);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles little, receiver much
      send_idle_pct = 6;
      recv_idle_pct = 56;
      test_directed();
      test_random_sequences(6, 56, 40);
      // the other way round
      test_random_sequences(56, 6, 40);
      // no idling at all
      test_position_wrap();
      test_output_backpressure();
      settle();

      $display("run covered %0d samples and %0d envelope items over %0d radius writes",
               samples_sent, checked_count, radius_writes);
      $display("radius 0..31, short and single-sample sequences, position wrap, hold-off");
      if (error_count == 0 && env_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/smme_pkg.sv
rtl/core/smme_ram.sv
rtl/core/smme_deque.sv
rtl/core/smme_ctrl.sv
rtl/core/sliding_min_max_envelope_core.sv
verif/sliding_min_max_envelope_core_tb.sv
